FILE: rtl/bba_pkg.sv
// shared types and constants for the bitmap block allocator
// no dependencies; used by bba_scan and bitmap_block_allocator in rtl/
package bba_pkg;

    localparam int BBA_NUM_BLOCKS = 1024;
    localparam int BBA_WORD_W     = 32;
    localparam int BBA_BIT_W      = 5;

    localparam int BBA_BLOCK_W    = 11;
    localparam int BBA_GRANT_W    = 10;
    localparam int BBA_COUNT_W    = 11;
    localparam int BBA_STATUS_W   = 2;
    localparam int BBA_IN_DATA_W  = 16;
    localparam int BBA_OUT_DATA_W = 24;

    // request kinds carried on s_tuser
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    typedef enum logic [BBA_STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic                 found;
        logic [BBA_BIT_W-1:0] bit_idx;
    } t_scan_res;

endpackage

FILE: rtl/bba_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bba_scan.sv
// first-free finder for one bitmap word, padding bits of the last word count as used
// depends on bba_pkg
module bba_scan
    import bba_pkg::*;
#(
    parameter int LAST_BITS = BBA_WORD_W
) (
    input  logic [BBA_WORD_W-1:0] i_word,
    input  logic                  i_last,
    output t_scan_res             o_res
);

    localparam logic [BBA_WORD_W:0] LIVE_MASK =
        ((BBA_WORD_W+1)'(1) << LAST_BITS) - (BBA_WORD_W+1)'(1);
    localparam logic [BBA_WORD_W-1:0] PAD_MASK = ~LIVE_MASK[BBA_WORD_W-1:0];

    logic [BBA_WORD_W-1:0] w_eff;

    assign w_eff = i_last ? (i_word | PAD_MASK) : i_word;

    // walk from the top so the lowest zero bit wins
    always_comb begin
        o_res.found   = ~&w_eff;
        o_res.bit_idx = '0;
        for (int b = BBA_WORD_W - 1; b >= 0; b--) begin
            if (!w_eff[b]) begin
                o_res.bit_idx = BBA_BIT_W'(b);
            end
        end
    end

endmodule

FILE: rtl/bitmap_block_allocator.sv
// first-fit bitmap block allocator, map kept as 32-bit words in a ram
// allocate: first-fit scan from word 0, one word checked per cycle, up to the last word;
// no scan when no block is free; free: read the word, then clear its bit; out-of-range: no map access
// one item in flight at a time; the result waits in an output register
// reset: synchronous active-low; then a clearing pass over all ceil(NUM_BLOCKS/32) words
// zeroes the map, during which no item is accepted
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = BBA_NUM_BLOCKS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [BBA_IN_DATA_W-1:0]  s_tdata,   // [10:0] block, [15:11] zero
    input  logic                      s_tuser,   // [0] func
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [BBA_OUT_DATA_W-1:0] m_tdata    // [1:0] status, [11:2] granted_block,
                                                 // [22:12] free_count, [23] zero
);

    localparam int NUM_WORDS = (NUM_BLOCKS + BBA_WORD_W - 1) / BBA_WORD_W;
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int LAST_BITS = NUM_BLOCKS - (NUM_WORDS - 1) * BBA_WORD_W;
    localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
    localparam logic [WA_W-1:0]  LAST_WA   = WA_W'(NUM_WORDS - 1);
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(NUM_BLOCKS);

    t_state r_state, n_state;

    logic [WA_W-1:0]       r_addr, n_addr;
    logic [BBA_BIT_W-1:0]  r_bit, n_bit;
    logic [CNT_W-1:0]      r_free_cnt, n_free_cnt;
    t_status               r_res_status, n_res_status;
    logic [BBA_GRANT_W-1:0] r_res_grant, n_res_grant;
    logic                  r_out_valid, n_out_valid;
    logic [BBA_OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                  w_accept;
    logic [BBA_BLOCK_W-1:0] w_blk;
    logic                  w_in_range;
    logic [WA_W-1:0]       w_blk_word;
    logic                  w_we;
    logic [WA_W-1:0]       w_raddr;
    logic [BBA_WORD_W-1:0] w_wdata;
    logic [BBA_WORD_W-1:0] w_rdata;
    logic                  w_out_free;
    t_scan_res             w_scan;
    logic [31:0]           w_grant32;
    logic [31:0]           w_cnt32;
    logic [31:0]           w_blk_word32;

    assign w_blk        = s_tdata[BBA_BLOCK_W-1:0];
    assign w_in_range   = {21'd0, w_blk} < 32'(NUM_BLOCKS);
    assign w_blk_word32 = {21'd0, w_blk} >> BBA_BIT_W;
    assign w_blk_word   = w_blk_word32[WA_W-1:0];
    assign w_accept     = s_tvalid && s_tready;
    assign w_out_free   = !r_out_valid || m_tready;
    assign w_grant32    = {{(32-WA_W-BBA_BIT_W){1'b0}}, r_addr, w_scan.bit_idx};
    assign w_cnt32      = {{(32-CNT_W){1'b0}}, r_free_cnt};

    bba_ram #(
        .WIDTH (BBA_WORD_W),
        .DEPTH (NUM_WORDS),
        .AW    (WA_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bba_scan #(
        .LAST_BITS (LAST_BITS)
    ) u_scan (
        .i_word (w_rdata),
        .i_last (r_addr == LAST_WA),
        .o_res  (w_scan)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_addr == LAST_WA) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (s_tuser == FN_FREE) begin
                        n_state = w_in_range ? S_FREE : S_RESP;
                    end else begin
                        n_state = (r_free_cnt == '0) ? S_RESP : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_scan.found || r_addr == LAST_WA) n_state = S_RESP;
            end
            S_FREE: n_state = S_RESP;
            S_RESP: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_addr       = r_addr;
        n_bit        = r_bit;
        n_free_cnt   = r_free_cnt;
        n_res_status = r_res_status;
        n_res_grant  = r_res_grant;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        s_tready     = 1'b0;
        w_we         = 1'b0;
        w_wdata      = '0;
        w_raddr      = r_addr;

        if (r_out_valid && m_tready) n_out_valid = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                w_we   = 1'b1;
                n_addr = r_addr + 1'b1;
            end
            S_IDLE: begin
                s_tready    = 1'b1;
                n_res_grant = '0;
                if (s_tuser == FN_FREE) begin
                    w_raddr      = w_blk_word;
                    n_addr       = w_blk_word;
                    n_bit        = w_blk[BBA_BIT_W-1:0];
                    n_res_status = w_in_range ? ST_OK : ST_RANGE;
                end else begin
                    w_raddr      = '0;
                    n_addr       = '0;
                    n_res_status = (r_free_cnt == '0) ? ST_FULL : ST_OK;
                end
            end
            S_SCAN: begin
                // read of the next word overlaps the check of this one
                w_raddr = r_addr + 1'b1;
                if (w_scan.found) begin
                    w_we         = 1'b1;
                    w_wdata      = w_rdata | (BBA_WORD_W'(1) << w_scan.bit_idx);
                    n_free_cnt   = r_free_cnt - 1'b1;
                    n_res_status = ST_OK;
                    n_res_grant  = w_grant32[BBA_GRANT_W-1:0];
                end else begin
                    n_addr = r_addr + 1'b1;
                    if (r_addr == LAST_WA) n_res_status = ST_FULL;
                end
            end
            S_FREE: begin
                if (w_rdata[r_bit]) begin
                    w_we       = 1'b1;
                    w_wdata    = w_rdata & ~(BBA_WORD_W'(1) << r_bit);
                    n_free_cnt = r_free_cnt + 1'b1;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, w_cnt32[BBA_COUNT_W-1:0], r_res_grant,
                                   r_res_status};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_free_cnt  <= CNT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_free_cnt  <= n_free_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit        <= n_bit;
        r_res_status <= n_res_status;
        r_res_grant  <= n_res_grant;
        r_out_data   <= n_out_data;
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= CNT_RESET)
        else $error("free count above block count");

    a_scan_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_free_cnt != '0)
        else $error("scan started with no free block");

    a_scan_finds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN && r_addr == LAST_WA |-> w_scan.found)
        else $error("count says free but map is full");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> r_state != S_IDLE && r_state != S_RESP)
        else $error("map written outside an operation");
`endif

endmodule

FILE: sim/bitmap_block_allocator_test.sv
`timescale 1ns / 1ps
// self-checking testbench for bitmap_block_allocator: first-fit allocate and free requests
// checked against an in-bench allocation map; depends on rtl/bba_pkg.sv and the allocator
module bitmap_block_allocator_test;
    import bba_pkg::*;

    localparam int NUM_BLOCKS  = BBA_NUM_BLOCKS;
    localparam int SETTLE_CYC  = 40;       // longest allocate scan plus margin
    localparam int HOLD_CYC    = 300;      // long receiver hold-off
    localparam int RANDOM_ITEMS = 170;     // per idling phase

    typedef struct {
        t_status                status;
        logic [BBA_GRANT_W-1:0] granted;
        logic [BBA_COUNT_W-1:0] free_count;
    } t_alloc_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [BBA_IN_DATA_W-1:0]  s_tdata = '0;    // [10:0] block, [15:11] zero
    logic                      s_tuser = 1'b0;  // [0] func
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [BBA_OUT_DATA_W-1:0] m_tdata;         // [1:0] status, [11:2] granted_block,
                                                // [22:12] free_count, [23] zero

    // allocation map as the block should hold it
    bit            block_used [NUM_BLOCKS];
    int            free_total = NUM_BLOCKS;
    t_alloc_result pending_results [$];

    int req_gap_pct   = 0;
    int rsp_stall_pct = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    int mismatch_count = 0;
    int results_checked = 0;
    int alloc_reqs = 0;
    int free_reqs = 0;
    int full_seen = 0;
    int range_seen = 0;

    int gap_by_phase   [4] = '{0, 63, 0, 32};
    int stall_by_phase [4] = '{0, 0, 63, 32};

    bitmap_block_allocator #(.NUM_BLOCKS(NUM_BLOCKS)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_alloc_result predict_request(input logic fn,
                                                      input logic [BBA_BLOCK_W-1:0] blk);
        t_alloc_result r;
        int idx;
        r.status  = ST_OK;
        r.granted = '0;
        if (fn == FN_ALLOC) begin
            idx = 0;
            while (idx < NUM_BLOCKS && block_used[idx])
                idx++;
            if (idx == NUM_BLOCKS) begin
                r.status = ST_FULL;
            end else begin
                block_used[idx] = 1'b1;
                free_total--;
                r.granted = idx[BBA_GRANT_W-1:0];
            end
        end else if (blk >= NUM_BLOCKS) begin
            r.status = ST_RANGE;
        end else if (block_used[blk]) begin
            block_used[blk] = 1'b0;
            free_total++;
        end
        r.free_count = free_total[BBA_COUNT_W-1:0];
        return r;
    endfunction

    // offer one item, keep it until accepted, then record what it should produce
    task automatic issue_request(input logic fn, input logic [BBA_BLOCK_W-1:0] blk);
        while ($urandom_range(99) < req_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {{(BBA_IN_DATA_W-BBA_BLOCK_W){1'b0}}, blk};
        do @(posedge i_clk); while (s_tready !== 1'b1);
        pending_results.push_back(predict_request(fn, blk));
        if (fn == FN_ALLOC)
            alloc_reqs++;
        else
            free_reqs++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic set_idling(input int gap_pct, input int stall_pct);
        req_gap_pct   = gap_pct;
        rsp_stall_pct = stall_pct;
    endtask

    task automatic issue_random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            issue_request(FN_ALLOC, BBA_BLOCK_W'($urandom_range(2047)));
        else if (pick < 85)
            issue_request(FN_FREE, BBA_BLOCK_W'($urandom_range(NUM_BLOCKS - 1)));
        else if (pick < 93)
            issue_request(FN_FREE, BBA_BLOCK_W'($urandom_range(31)));  // churn near the search start
        else
            issue_request(FN_FREE, BBA_BLOCK_W'($urandom_range(2047, NUM_BLOCKS)));
    endtask

    task automatic test_corner_requests();
        set_idling(0, 0);
        issue_request(FN_ALLOC, 11'd0);
        issue_request(FN_ALLOC, 11'h555);       // block field ignored on allocate
        issue_request(FN_ALLOC, 11'h7FF);
        issue_request(FN_FREE, 11'd1);          // used block
        issue_request(FN_FREE, 11'd1);          // already free
        issue_request(FN_ALLOC, 11'd0);         // lowest hole is reused
        issue_request(FN_FREE, 11'd1023);       // top block, never used
        issue_request(FN_FREE, 11'd1024);       // first number out of range
        issue_request(FN_FREE, 11'h7FF);        // largest number
        issue_request(FN_FREE, 11'd0);
        issue_request(FN_ALLOC, 11'h2AA);
        issue_request(FN_FREE, 11'd2);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        set_idling(0, 0);
        hold_requests++;
        repeat (12)
            issue_random_request();
        // sender stays quiet until the block has answered everything
        wait_drained();
        repeat (4)
            issue_random_request();
        wait_drained();
    endtask

    task automatic test_fill_to_full();
        int n;
        n = 0;
        while (free_total > 0) begin
            set_idling(gap_by_phase[(n / 256) % 4], stall_by_phase[(n / 256) % 4]);
            issue_request(FN_ALLOC, BBA_BLOCK_W'($urandom_range(2047)));
            n++;
        end
        set_idling(32, 32);
        repeat (3)
            issue_request(FN_ALLOC, BBA_BLOCK_W'($urandom_range(2047)));
        issue_request(FN_FREE, 11'd1023);
        issue_request(FN_ALLOC, 11'd0);         // full-length scan to the last word
        issue_request(FN_FREE, 11'd512);
        issue_request(FN_FREE, 11'd3);
        issue_request(FN_ALLOC, 11'd0);
        issue_request(FN_ALLOC, 11'd0);
        issue_request(FN_ALLOC, 11'd0);
        wait_drained();
    endtask

    task automatic test_random_mix();
        for (int p = 0; p < 4; p++) begin
            set_idling(gap_by_phase[p], stall_by_phase[p]);
            repeat (RANDOM_ITEMS)
                issue_random_request();
        end
        wait_drained();
    endtask

    // receiver side: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYC;
            m_tready     <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_alloc_result exp_r;
        if (m_tvalid === 1'b1 && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: m_tdata %h", m_tdata);
                mismatch_count++;
            end else begin
                exp_r = pending_results.pop_front();
                results_checked++;
                if (exp_r.status == ST_FULL)
                    full_seen++;
                if (exp_r.status == ST_RANGE)
                    range_seen++;
                if (m_tdata[1:0] !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_tdata[1:0]);
                    mismatch_count++;
                end
                if (m_tdata[11:2] !== exp_r.granted) begin
                    $error("granted_block: expected %0d, got %0d",
                           exp_r.granted, m_tdata[11:2]);
                    mismatch_count++;
                end
                if (m_tdata[22:12] !== exp_r.free_count) begin
                    $error("free_count: expected %0d, got %0d",
                           exp_r.free_count, m_tdata[22:12]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_requests();
        test_output_backpressure();
        test_fill_to_full();
        test_random_mix();
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        $display("checked %0d results from %0d allocate and %0d free requests",
                 results_checked, alloc_reqs, free_reqs);
        $display("%0d allocations found the map full, %0d frees were out of range",
                 full_seen, range_seen);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
